### src/cylinder_mesh_tessellator_top_assert.svh
// Assertion macros for the cylinder tessellator checker.
`ifndef CYLINDER_MESH_TESSELLATOR_TOP_ASSERT_SVH
`define CYLINDER_MESH_TESSELLATOR_TOP_ASSERT_SVH
// Assert that an antecedent implies a consequent on the same edge.
`define CMT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that an antecedent implies a consequent on the next edge.
`define CMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### src/cmt_pkg.sv
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared constants, types and tables of the cylinder tessellator.
// ----------------------------------------------------------------------------
package cmt_pkg;

    localparam int MAX_SEGMENTS  = 256;
    localparam int VERTS         = 12;
    localparam int CORDIC_STEPS  = 16;
    localparam int ONE_Q14       = 16384;
    localparam logic signed [22:0] CORDIC_START = 23'sd636751;

    localparam logic [1:0] REG_RADIUS  = 2'd0;
    localparam logic [1:0] REG_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_SEGMENT = 2'd2;

    // point select: axis, rim point at the start angle, rim point at the end angle
    localparam logic [1:0] PT_AXIS = 2'd0;
    localparam logic [1:0] PT_P1   = 2'd1;
    localparam logic [1:0] PT_P2   = 2'd2;
    // normal select
    localparam logic [2:0] NK_N1   = 3'd1;
    localparam logic [2:0] NK_N2   = 3'd2;
    localparam logic [2:0] NK_UP   = 3'd3;
    localparam logic [2:0] NK_DOWN = 3'd4;

    typedef struct packed {
        logic [1:0] point;
        logic       top;
        logic [2:0] norm;
    } slot_info_t;

    function automatic logic [15:0] turn_atan(input logic [3:0] k);
        logic [15:0] v;
        case (k)
            4'd0:  v = 16'd8192;
            4'd1:  v = 16'd4836;
            4'd2:  v = 16'd2555;
            4'd3:  v = 16'd1297;
            4'd4:  v = 16'd651;
            4'd5:  v = 16'd326;
            4'd6:  v = 16'd163;
            4'd7:  v = 16'd81;
            4'd8:  v = 16'd41;
            4'd9:  v = 16'd20;
            4'd10: v = 16'd10;
            4'd11: v = 16'd5;
            4'd12: v = 16'd3;
            4'd13: v = 16'd1;
            4'd14: v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic slot_info_t slot_info(input logic [3:0] s);
        slot_info_t v;
        case (s)
            4'd0:  v = '{PT_P1,   1'b0, NK_N1};
            4'd1:  v = '{PT_P2,   1'b0, NK_N2};
            4'd2:  v = '{PT_P1,   1'b1, NK_N1};
            4'd3:  v = '{PT_P1,   1'b1, NK_N1};
            4'd4:  v = '{PT_P2,   1'b0, NK_N2};
            4'd5:  v = '{PT_P2,   1'b1, NK_N2};
            4'd6:  v = '{PT_AXIS, 1'b1, NK_UP};
            4'd7:  v = '{PT_P1,   1'b1, NK_UP};
            4'd8:  v = '{PT_P2,   1'b1, NK_UP};
            4'd9:  v = '{PT_AXIS, 1'b0, NK_DOWN};
            4'd10: v = '{PT_P2,   1'b0, NK_DOWN};
            default: v = '{PT_P1, 1'b0, NK_DOWN};
        endcase
        return v;
    endfunction

endpackage

### src/cmt_cordic.sv
// ----------------------------------------------------------------------------
// cmt_cordic
// Pipelined 16-step CORDIC: one rotation step per stage, phase to Q1.14
// cosine and sine, with quadrant fold at the output. Advances when en is high.
// ----------------------------------------------------------------------------
module cmt_cordic
    import cmt_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [15:0]         phase,
    output logic signed [15:0]  cos_q,
    output logic signed [15:0]  sin_q
);

    logic signed [23:0] x_reg [CORDIC_STEPS+1];
    logic signed [23:0] y_reg [CORDIC_STEPS+1];
    logic signed [16:0] z_reg [CORDIC_STEPS+1];
    logic [1:0]         q_reg [CORDIC_STEPS+1];
    logic               zero_reg [CORDIC_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= 24'(CORDIC_START);
            y_reg[0]    <= '0;
            z_reg[0]    <= {3'b000, phase[13:0]};
            q_reg[0]    <= phase[15:14];
            zero_reg[0] <= (phase[13:0] == 14'd0);
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        logic signed [23:0] dx;
        logic signed [23:0] dy;
        logic signed [16:0] a;
        assign dx = x_reg[k] >>> k;
        assign dy = y_reg[k] >>> k;
        assign a  = 17'(turn_atan(4'(k)));
        // arithmetic shift is floor division
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[k][16])
                begin
                    x_reg[k+1] <= x_reg[k] - dy;
                    y_reg[k+1] <= y_reg[k] + dx;
                    z_reg[k+1] <= z_reg[k] - a;
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + dy;
                    y_reg[k+1] <= y_reg[k] - dx;
                    z_reg[k+1] <= z_reg[k] + a;
                end
                q_reg[k+1]    <= q_reg[k];
                zero_reg[k+1] <= zero_reg[k];
            end
        end
    end

    function automatic logic signed [15:0] round_clamp(input logic signed [23:0] v);
        logic [23:0]        m;
        logic [23:0]        r;
        logic signed [24:0] s;
        m = v[23] ? 24'(-v) : v;
        r = (m + 24'd32) >> 6;
        if (r > 24'(ONE_Q14))
            r = 24'(ONE_Q14);
        s = v[23] ? -$signed({1'b0, r}) : $signed({1'b0, r});
        return s[15:0];
    endfunction

    logic signed [15:0] xr;
    logic signed [15:0] yr;
    logic [1:0]         q;
    logic signed [15:0] c_next;
    logic signed [15:0] s_next;

    always_comb
    begin
        q = q_reg[CORDIC_STEPS];
        if (zero_reg[CORDIC_STEPS])
        begin
            xr = 16'(ONE_Q14);
            yr = '0;
        end
        else
        begin
            xr = round_clamp(x_reg[CORDIC_STEPS]);
            yr = round_clamp(y_reg[CORDIC_STEPS]);
        end
        case (q)
            2'd0:    begin c_next = xr;  s_next = yr;  end
            2'd1:    begin c_next = -yr; s_next = xr;  end
            2'd2:    begin c_next = -xr; s_next = -yr; end
            default: begin c_next = yr;  s_next = -xr; end
        endcase
    end

    logic signed [15:0] cos_reg;
    logic signed [15:0] sin_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= c_next;
            sin_reg <= s_next;
        end
    end
    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

### src/cylinder_mesh_tessellator_top.sv
// Pipeline: 17-step phase divide, 18-stage CORDIC, scale multiply, vertex buffer;
// the buffer then emits one vertex per cycle while out_ready is high.
// Indexes enter while the pipeline advances, which stalls on a busy vertex buffer;
// an out-of-range index gives one word and frees the output once it is taken.
// Reset: asynchronous, active low; registers return to radius 256, height 256,
// 16 segments, and the pipeline empties.
// ----------------------------------------------------------------------------
// cylinder_mesh_tessellator_top
// Cylinder segment tessellator: index in, twelve vertex words (or one error word) out.
// ----------------------------------------------------------------------------
module cylinder_mesh_tessellator_top
    import cmt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          segment_index,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [3:0]          vertex_slot,
    output logic signed [16:0]  pos_x,
    output logic signed [16:0]  pos_y,
    output logic signed [16:0]  pos_z,
    output logic signed [15:0]  norm_x,
    output logic signed [15:0]  norm_y,
    output logic signed [15:0]  norm_z,
    output logic                index_error,
    output logic                last
);

    localparam int DIV_STEPS = 17;   // low dividend bits of i*65536/n

    logic [15:0] radius_reg;
    logic [15:0] height_reg;
    logic [8:0]  segment_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= 16'd256;
            height_reg  <= 16'd256;
            segment_reg <= 9'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RADIUS:  radius_reg  <= cfg_data;
                REG_HEIGHT:  height_reg  <= cfg_data;
                REG_SEGMENT: segment_reg <= cfg_data[8:0];
                default:     ;
            endcase
        end
    end

    logic [8:0] n_eff;
    always_comb
    begin
        if (segment_reg < 9'd3)
            n_eff = 9'd3;
        else if (segment_reg > 9'(MAX_SEGMENTS))
            n_eff = 9'(MAX_SEGMENTS);
        else
            n_eff = segment_reg;
    end

    // pipeline advances whenever the output buffer can take the head word
    logic adv;
    logic buf_free;

    // ---- restoring divide pipeline: two dividends share one divisor ----
    logic        dv_reg  [DIV_STEPS+1];
    logic        de_reg  [DIV_STEPS+1];
    logic [8:0]  dn_reg  [DIV_STEPS+1];
    logic [16:0] n1_reg  [DIV_STEPS+1];
    logic [16:0] n2_reg  [DIV_STEPS+1];
    logic [8:0]  r1_reg  [DIV_STEPS+1];
    logic [8:0]  r2_reg  [DIV_STEPS+1];
    logic [15:0] q1_reg  [DIV_STEPS+1];
    logic [15:0] q2_reg  [DIV_STEPS+1];

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    logic [8:0] idx_inc;
    assign idx_inc = {1'b0, segment_index} + 9'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else if (adv)
            dv_reg[0] <= in_acc;
    end

    // start from the remainder of the dividend's upper bits (already below n);
    // keep only the low 16 quotient bits, which are the turn phase
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            de_reg[0] <= ({1'b0, segment_index} >= n_eff);
            dn_reg[0] <= n_eff;
            n1_reg[0] <= {segment_index[0], 16'd0};
            n2_reg[0] <= {idx_inc[0], 16'd0};
            r1_reg[0] <= {2'b00, segment_index[7:1]};
            r2_reg[0] <= {1'b0, idx_inc[8:1]};
            q1_reg[0] <= '0;
            q2_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [9:0] t1;
        logic [9:0] t2;
        logic       g1;
        logic       g2;
        assign t1 = {r1_reg[k], n1_reg[k][16]};
        assign t2 = {r2_reg[k], n2_reg[k][16]};
        assign g1 = t1 >= {1'b0, dn_reg[k]};
        assign g2 = t2 >= {1'b0, dn_reg[k]};
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k+1] <= 1'b0;
            else if (adv)
                dv_reg[k+1] <= dv_reg[k];
        end
        // shift dividend left one bit a stage; quotient bit from compare
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                de_reg[k+1] <= de_reg[k];
                dn_reg[k+1] <= dn_reg[k];
                n1_reg[k+1] <= {n1_reg[k][15:0], 1'b0};
                n2_reg[k+1] <= {n2_reg[k][15:0], 1'b0};
                r1_reg[k+1] <= g1 ? 9'(t1 - {1'b0, dn_reg[k]}) : t1[8:0];
                r2_reg[k+1] <= g2 ? 9'(t2 - {1'b0, dn_reg[k]}) : t2[8:0];
                q1_reg[k+1] <= {q1_reg[k][14:0], g1};
                q2_reg[k+1] <= {q2_reg[k][14:0], g2};
            end
        end
    end

    // ---- CORDIC stage ----
    logic signed [15:0] c1;
    logic signed [15:0] s1;
    logic signed [15:0] c2;
    logic signed [15:0] s2;

    cmt_cordic u_cordic1 (
        .clk   (clk),
        .en    (adv),
        .phase (q1_reg[DIV_STEPS]),
        .cos_q (c1),
        .sin_q (s1)
    );

    cmt_cordic u_cordic2 (
        .clk   (clk),
        .en    (adv),
        .phase (q2_reg[DIV_STEPS]),
        .cos_q (c2),
        .sin_q (s2)
    );

    // side-band delay matching the CORDIC and the product stage (CORDIC_STEPS + 3)
    localparam int CD = CORDIC_STEPS + 3;
    logic cv_reg [CD];
    logic ce_reg [CD];
    for (genvar k = 0; k < CD; k++)
    begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[k] <= 1'b0;
            else if (adv)
                cv_reg[k] <= (k == 0) ? dv_reg[DIV_STEPS] : cv_reg[(k == 0) ? 0 : k-1];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
                ce_reg[k] <= (k == 0) ? de_reg[DIV_STEPS] : ce_reg[(k == 0) ? 0 : k-1];
        end
    end
    // c1 etc. valid alongside cv_reg[CD-2]; product stage registers at CD-1
    logic signed [32:0] m_reg [4];
    logic signed [15:0] c1_reg;
    logic signed [15:0] s1_reg;
    logic signed [15:0] c2_reg;
    logic signed [15:0] s2_reg;
    logic signed [16:0] rad_s;
    assign rad_s = $signed({1'b0, radius_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg[0] <= 33'(rad_s) * 33'(c1);
            m_reg[1] <= 33'(rad_s) * 33'(s1);
            m_reg[2] <= 33'(rad_s) * 33'(c2);
            m_reg[3] <= 33'(rad_s) * 33'(s2);
            c1_reg   <= c1;
            s1_reg   <= s1;
            c2_reg   <= c2;
            s2_reg   <= s2;
        end
    end

    function automatic logic signed [16:0] rnd14(input logic signed [32:0] v);
        logic [32:0] m;
        logic [32:0] r;
        logic signed [33:0] s;
        m = v[32] ? 33'(-v) : v;
        r = (m + 33'd8192) >> 14;
        s = v[32] ? -$signed({1'b0, r}) : $signed({1'b0, r});
        return s[16:0];
    endfunction

    // ---- vertex buffer: holds one segment, emits one word a cycle while out_ready ----
    logic               head_v;
    logic               head_e;
    assign head_v = cv_reg[CD-1];
    assign head_e = ce_reg[CD-1];

    logic               bv_reg;
    logic               be_reg;
    logic [3:0]         slot_reg;
    logic signed [16:0] px1_reg;
    logic signed [16:0] pz1_reg;
    logic signed [16:0] px2_reg;
    logic signed [16:0] pz2_reg;
    logic signed [15:0] bc1_reg;
    logic signed [15:0] bs1_reg;
    logic signed [15:0] bc2_reg;
    logic signed [15:0] bs2_reg;

    logic word_last;
    assign word_last = be_reg || (slot_reg == 4'(VERTS - 1));
    assign buf_free  = !bv_reg || (out_ready && word_last);
    assign adv       = buf_free || !head_v;
    assign in_ready  = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg   <= 1'b0;
            slot_reg <= '0;
        end
        else if (bv_reg && out_ready && !word_last)
            slot_reg <= slot_reg + 4'd1;
        else if (buf_free)
        begin
            bv_reg   <= head_v;
            slot_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_free && head_v)
        begin
            be_reg  <= head_e;
            px1_reg <= rnd14(m_reg[0]);
            pz1_reg <= rnd14(m_reg[1]);
            px2_reg <= rnd14(m_reg[2]);
            pz2_reg <= rnd14(m_reg[3]);
            bc1_reg <= c1_reg;
            bs1_reg <= s1_reg;
            bc2_reg <= c2_reg;
            bs2_reg <= s2_reg;
        end
    end

    slot_info_t si;
    assign si = slot_info(slot_reg);

    always_comb
    begin
        vertex_slot = slot_reg;
        pos_x  = '0;
        pos_z  = '0;
        pos_y  = '0;
        norm_x = '0;
        norm_y = '0;
        norm_z = '0;
        if (!be_reg)
        begin
            case (si.point)
                PT_P1:   begin pos_x = px1_reg; pos_z = pz1_reg; end
                PT_P2:   begin pos_x = px2_reg; pos_z = pz2_reg; end
                default: ;
            endcase
            pos_y = si.top ? $signed({1'b0, height_reg}) : 17'sd0;
            case (si.norm)
                NK_N1:   begin norm_x = bc1_reg; norm_z = bs1_reg; end
                NK_N2:   begin norm_x = bc2_reg; norm_z = bs2_reg; end
                NK_UP:   norm_y = 16'(ONE_Q14);
                default: norm_y = -16'(ONE_Q14);
            endcase
        end
        else
            vertex_slot = '0;
    end

    assign out_valid   = bv_reg;
    assign index_error = be_reg;
    assign last        = word_last;

endmodule

### src/cylinder_mesh_tessellator_top_chk.sv
// ----------------------------------------------------------------------------
// cylinder_mesh_tessellator_top_chk
// Port-level checks of the tessellator, bound to the top level.
// ----------------------------------------------------------------------------
`include "cylinder_mesh_tessellator_top_assert.svh"
module cylinder_mesh_tessellator_top_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] vertex_slot,
    input logic       index_error,
    input logic       last
);
    `CMT_ASSERT_SAME(a_err_single, clk, rst_n, out_valid && index_error, last && vertex_slot == 4'd0)
    `CMT_ASSERT_SAME(a_last_slot, clk, rst_n, out_valid && !index_error, last == (vertex_slot == 4'd11))
    `CMT_ASSERT_NEXT(a_slot_step, clk, rst_n, out_valid && out_ready && !last, out_valid && vertex_slot == $past(vertex_slot) + 4'd1)
    `CMT_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(vertex_slot))
endmodule

bind cylinder_mesh_tessellator_top cylinder_mesh_tessellator_top_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .vertex_slot (vertex_slot),
    .index_error (index_error),
    .last        (last)
);

### dv/cylinder_mesh_tessellator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cylinder_mesh_tessellator_top_tb
// Self-checking bench: segment indexes go in under bursty traffic and random
// output stalls. Each vertex word is compared with a local CORDIC predictor
// across several radius, height and segment count settings.
// ----------------------------------------------------------------------------
module cylinder_mesh_tessellator_top_tb;
    import cmt_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int TAIL       = 40;

    typedef struct packed {
        logic [3:0]         slot;
        logic signed [16:0] px;
        logic signed [16:0] py;
        logic signed [16:0] pz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               err;
        logic               last;
    } vertex_word_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         segment_index;
    logic               out_valid;
    logic               out_ready;
    logic [3:0]         vertex_slot;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               index_error;
    logic               last;

    vertex_word_t expected_vertices[$];
    int           mismatches;
    int           idle_cycles;
    bit           bursty;
    int           burst_left;
    bit           stall_on;
    int           stall_run;

    logic [15:0] radius_q88;
    logic [15:0] height_q88;
    logic [8:0]  seg_count;

    cylinder_mesh_tessellator_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .segment_index(segment_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .vertex_slot(vertex_slot), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .index_error(index_error), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint round_shift(input longint v, input int k);
        longint half;
        half = longint'(1) << (k - 1);
        if (v >= 0)
            return (v + half) >>> k;
        return -((-v + half) >>> k);
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > ONE_Q14)
            return ONE_Q14;
        if (v < -ONE_Q14)
            return -ONE_Q14;
        return v;
    endfunction

    task automatic phase_cos_sin(input logic [15:0] phase, output longint c, output longint s);
        longint angle_step[16];
        longint x, y, cx, cy, z, dx, dy;
        angle_step = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
        x = ONE_Q14;
        y = 0;
        if (phase[13:0] != 0)
        begin
            cx = CORDIC_START;
            cy = 0;
            z  = phase[13:0];
            for (int k = 0; k < 16; k++)
            begin
                dx = cy >>> k;
                dy = cx >>> k;
                if (z >= 0)
                begin
                    cx -= dx; cy += dy; z -= angle_step[k];
                end
                else
                begin
                    cx += dx; cy -= dy; z += angle_step[k];
                end
            end
            x = clamp_unit(round_shift(cx, 6));
            y = clamp_unit(round_shift(cy, 6));
        end
        case (phase[15:14])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic int effective_segments();
        if (seg_count < 3)
            return 3;
        if (seg_count > MAX_SEGMENTS)
            return MAX_SEGMENTS;
        return seg_count;
    endfunction

    // Queue the twelve vertex words (or the single error word) for one index.
    task automatic predict_segment(input logic [7:0] idx);
        int           n;
        longint       c[3], s[3], px[3], pz[3];
        logic [15:0]  a1, a2;
        vertex_word_t w;
        slot_info_t   si;
        n = effective_segments();
        w = '0;
        if (idx >= n)
        begin
            w.err  = 1'b1;
            w.last = 1'b1;
            expected_vertices = {expected_vertices, w};
            return;
        end
        a1 = 16'((longint'(idx) * 65536) / n);
        a2 = 16'((longint'(idx) + 1) * 65536 / n);
        c[0] = 0;
        s[0] = 0;
        phase_cos_sin(a1, c[1], s[1]);
        phase_cos_sin(a2, c[2], s[2]);
        for (int j = 0; j < 3; j++)
        begin
            px[j] = round_shift(longint'(radius_q88) * c[j], 14);
            pz[j] = round_shift(longint'(radius_q88) * s[j], 14);
        end
        for (int v = 0; v < VERTS; v++)
        begin
            si     = slot_info(4'(v));
            w      = '0;
            w.slot = 4'(v);
            w.px   = 17'(px[si.point]);
            w.pz   = 17'(pz[si.point]);
            w.py   = si.top ? 17'(height_q88) : 17'sd0;
            if (si.norm == NK_N1 || si.norm == NK_N2)
            begin
                w.nx = 16'(c[si.norm]);
                w.nz = 16'(s[si.norm]);
            end
            else
                w.ny = (si.norm == NK_UP) ? 16'sd16384 : -16'sd16384;
            w.last = (v == VERTS - 1);
            expected_vertices = {expected_vertices, w};
        end
    endtask

    // Result checker and receiver stall pattern.
    always @(posedge clk)
    begin
        vertex_word_t got, want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{vertex_slot, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                        index_error, last};
                if (expected_vertices.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: slot %0d err %0b", vertex_slot, index_error);
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: exp slot %0d pos %0d %0d %0d nrm %0d %0d %0d e%0b l%0b",
                                     want.slot, want.px, want.py, want.pz, want.nx,
                                     want.ny, want.nz, want.err, want.last);
                            $display("          got slot %0d pos %0d %0d %0d nrm %0d %0d %0d e%0b l%0b",
                                     got.slot, got.px, got.py, got.pz, got.nx,
                                     got.ny, got.nz, got.err, got.last);
                        end
                    end
                end
            end
            // alternate stretches of random stalls with stretches of none
            if (stall_run == 0)
            begin
                stall_on  <= ($urandom_range(0, 2) != 0);
                stall_run <= $urandom_range(5, 60);
            end
            else
                stall_run <= stall_run - 1;
            out_ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Raise valid, hold until accepted, then predict. Valid stays high in a burst.
    task automatic send_index(input logic [7:0] idx);
        in_valid      <= 1'b1;
        segment_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_segment(idx);
        if (bursty)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                burst_left = $urandom_range(0, 6);
            end
            else
                burst_left--;
        end
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_vertices.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_RADIUS:  radius_q88 = value;
            REG_HEIGHT:  height_q88 = value;
            REG_SEGMENT: seg_count  = value[8:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_index(8'd0);
        send_index(8'd15);
        send_index(8'd16);
        send_index(8'd255);
        go_idle();
    endtask

    task automatic test_extreme_sizes();
        write_reg(REG_RADIUS, 16'hFFFF);
        write_reg(REG_HEIGHT, 16'hFFFF);
        write_reg(REG_SEGMENT, 16'd3);
        send_index(8'd0);
        send_index(8'd2);
        send_index(8'd3);
        go_idle();
        write_reg(REG_RADIUS, 16'd0);
        write_reg(REG_HEIGHT, 16'd0);
        write_reg(REG_SEGMENT, 16'd256);
        send_index(8'd255);
        send_index(8'd128);
        go_idle();
    endtask

    task automatic test_count_clamp();
        write_reg(REG_RADIUS, 16'h0180);
        write_reg(REG_HEIGHT, 16'h0200);
        write_reg(REG_SEGMENT, 16'd0);
        send_index(8'd2);
        send_index(8'd3);
        go_idle();
        write_reg(REG_SEGMENT, 16'd2);
        send_index(8'd1);
        go_idle();
        write_reg(REG_SEGMENT, 16'd257);
        send_index(8'd255);
        go_idle();
        write_reg(REG_SEGMENT, 16'hFFFF);
        send_index(8'd170);
        send_index(8'd85);
        go_idle();
    endtask

    task automatic test_random_traffic();
        int n;
        for (int p = 0; p < 4; p++)
        begin
            write_reg(REG_RADIUS, (p == 0) ? 16'hFFFF : 16'($urandom));
            write_reg(REG_HEIGHT, 16'($urandom));
            write_reg(REG_SEGMENT, (p == 1) ? 16'd256 : 16'($urandom_range(0, 300)));
            bursty = (p != 2);
            n = effective_segments();
            for (int i = 0; i < 80; i++)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_index(8'($urandom_range(0, n - 1)));
                else
                    send_index(8'($urandom));
            end
            go_idle();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        segment_index = '0;
        out_ready     = 1'b0;
        mismatches    = 0;
        idle_cycles   = 0;
        bursty        = 1'b1;
        burst_left    = 0;
        stall_on      = 1'b0;
        stall_run     = 0;
        radius_q88    = 16'd256;
        height_q88    = 16'd256;
        seg_count     = 9'd16;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_extreme_sizes();
        test_count_clamp();
        test_random_traffic();

        if (mismatches == 0 && expected_vertices.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
